// ----- hdl/laser_scan_to_points_core_macros.svh -----
// Assertion macros for the lidar scan to points core.
// Included by the RTL files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef LASER_SCAN_TO_POINTS_CORE_MACROS_SVH
`define LASER_SCAN_TO_POINTS_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LSTP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define LSTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lsp_pkg.sv -----
// Shared types, widths and constants for the lidar scan to points core.
// No dependencies; imported by every module of the core.
package lsp_pkg;

	localparam int RANGE_W    = 16;
	localparam int IDX_W      = 12;
	localparam int ANG_W      = 16;
	localparam int OFF_W      = 16;
	localparam int OUT_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int XY_W       = 32;
	localparam int Z_W        = 33;
	localparam int GAIN_W     = 31;
	localparam int PROD_W     = XY_W + GAIN_W;
	localparam int FRAC_SHIFT = 44;
	localparam int SUM_W      = PROD_W - FRAC_SHIFT + 1;
	localparam int ATAN_LEN   = 24;

	localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SHIFT - 1);
	localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'((2 ** (OUT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0]  SAT_LO = SUM_W'(-(2 ** (OUT_W - 1)));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_LOW   = 3'd0,
		REG_RANGE_HIGH  = 3'd1,
		REG_ANGLE_START = 3'd2,
		REG_ANGLE_STEP  = 3'd3,
		REG_OFFSET_X    = 3'd4,
		REG_OFFSET_Y    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [RANGE_W-1:0]      range_low;
		logic [RANGE_W-1:0]      range_high;
		logic [ANG_W-1:0]        angle_start;
		logic signed [ANG_W-1:0] angle_step;
		logic signed [OFF_W-1:0] offset_x;
		logic signed [OFF_W-1:0] offset_y;
	} cfg_t;

	// rotation word between the front end and the CORDIC
	typedef struct packed {
		logic                   kept;
		logic                   done;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} rot_t;

	// rotated vector between the CORDIC and the output scaler
	typedef struct packed {
		logic                   kept;
		logic                   done;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
	} vec_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [Z_W-1:0] atan_at(input int unsigned i);
		case (i)
			0:  return 33'sd536870912;
			1:  return 33'sd316933406;
			2:  return 33'sd167458907;
			3:  return 33'sd85004756;
			4:  return 33'sd42667331;
			5:  return 33'sd21354465;
			6:  return 33'sd10679838;
			7:  return 33'sd5340245;
			8:  return 33'sd2670163;
			9:  return 33'sd1335087;
			10: return 33'sd667544;
			11: return 33'sd333772;
			12: return 33'sd166886;
			13: return 33'sd83443;
			14: return 33'sd41722;
			15: return 33'sd20861;
			16: return 33'sd10430;
			17: return 33'sd5215;
			18: return 33'sd2608;
			19: return 33'sd1304;
			20: return 33'sd652;
			21: return 33'sd326;
			22: return 33'sd163;
			23: return 33'sd81;
			default: return '0;
		endcase
	endfunction

endpackage

// ----- hdl/lsp_front.sv -----
// Front end: range window, beam angle and half-turn fold into a CORDIC start word.
// Two pipeline stages; depends on lsp_pkg and the assertion macro header.
`include "laser_scan_to_points_core_macros.svh"

module lsp_front #(
	parameter int unsigned MAX_SAMPLES = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lsp_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lsp_pkg::RANGE_W-1:0]  range_mm,
	input  logic [lsp_pkg::IDX_W-1:0]    sample_index,
	input  logic                         scan_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output lsp_pkg::rot_t                out_word
);
	import lsp_pkg::*;

	localparam int LIM_W = $clog2(MAX_SAMPLES + 1);
	localparam int CMP_W = (LIM_W > IDX_W) ? LIM_W : IDX_W;

	logic                     valid_s1;
	logic                     kept_s1;
	logic                     done_s1;
	logic [RANGE_W-1:0]       range_s1;
	logic [ANG_W-1:0]         turn_s1;
	logic                     valid_s2;
	rot_t                     word_s2;

	logic                     rdy_s1;
	logic                     rdy_s2;
	logic                     idx_ok;
	logic                     kept_c;
	logic [ANG_W+IDX_W-1:0]   prod_c;
	logic [ANG_W-1:0]         ang_c;
	logic signed [ANG_W:0]    sa_c;
	logic signed [ANG_W:0]    fold_c;
	logic                     flip_c;
	logic signed [XY_W-1:0]   mag_c;

	assign rdy_s2   = !valid_s2 || out_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign idx_ok = CMP_W'(sample_index) < CMP_W'(MAX_SAMPLES);
	assign kept_c = (range_mm >= cfg.range_low) && (range_mm <= cfg.range_high) && idx_ok;
	assign prod_c = sample_index * $unsigned(cfg.angle_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			kept_s1  <= kept_c;
			done_s1  <= scan_end;
			range_s1 <= range_mm;
			turn_s1  <= prod_c[ANG_W-1:0];
		end
	end

	// fold angles beyond a quarter turn by half a turn and negate the start vector
	assign ang_c = cfg.angle_start + turn_s1;
	assign sa_c  = $signed({ang_c[ANG_W-1], ang_c});
	assign mag_c = XY_W'({range_s1, 14'd0});

	always_comb begin
		if (sa_c > 17'sd16384) begin
			fold_c = sa_c - 17'sd32768;
			flip_c = 1'b1;
		end else if (sa_c < -17'sd16384) begin
			fold_c = sa_c + 17'sd32768;
			flip_c = 1'b1;
		end else begin
			fold_c = sa_c;
			flip_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			word_s2.kept <= kept_s1;
			word_s2.done <= done_s1;
			word_s2.x    <= flip_c ? -mag_c : mag_c;
			word_s2.y    <= '0;
			word_s2.z    <= {fold_c, 16'd0};
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

	`LSTP_ASSERT_NEXT(a_low_range_dropped,
		in_valid && in_ready && (range_mm < cfg.range_low),
		valid_s1 && !kept_s1,
		"range below window not dropped")
	`LSTP_ASSERT_NOW(a_folded_angle_in_half_turn,
		valid_s2,
		(word_s2.z <= 33'sd1073741824) && (word_s2.z >= -33'sd1073741824),
		"folded angle beyond a quarter turn")
	`LSTP_ASSERT_NEXT(a_stalled_word_held,
		valid_s2 && !out_ready,
		valid_s2 && $stable(word_s2),
		"stalled front-end word not held")

endmodule

// ----- hdl/lsp_cordic.sv -----
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
// Depends on lsp_pkg for the word types and the arctangent table.
module lsp_cordic #(
	parameter int unsigned STAGES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lsp_pkg::rot_t  in_word,
	output logic           out_valid,
	input  logic           out_ready,
	output lsp_pkg::vec_t  out_word
);
	import lsp_pkg::*;

	localparam int unsigned N = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

	rot_t rot_w   [N+1];
	logic valid_w [N+1];
	logic rdy     [N+1];

	assign rot_w[0]   = in_word;
	assign valid_w[0] = in_valid;
	assign rdy[N]     = out_ready;
	assign in_ready   = rdy[0];

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [Z_W-1:0] ATAN = atan_at(i);

		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		logic                   neg;
		logic                   valid_sn;
		rot_t                   rot_sn;

		assign dx  = $signed(rot_w[i].y) >>> i;
		assign dy  = $signed(rot_w[i].x) >>> i;
		assign neg = rot_w[i].z[Z_W-1];
		assign rdy[i] = !valid_sn || rdy[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn <= 1'b0;
			end else if (rdy[i]) begin
				valid_sn <= valid_w[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && valid_w[i]) begin
				rot_sn.kept <= rot_w[i].kept;
				rot_sn.done <= rot_w[i].done;
				if (neg) begin
					rot_sn.x <= rot_w[i].x + dx;
					rot_sn.y <= rot_w[i].y - dy;
					rot_sn.z <= rot_w[i].z + ATAN;
				end else begin
					rot_sn.x <= rot_w[i].x - dx;
					rot_sn.y <= rot_w[i].y + dy;
					rot_sn.z <= rot_w[i].z - ATAN;
				end
			end
		end

		assign rot_w[i+1]   = rot_sn;
		assign valid_w[i+1] = valid_sn;
	end

	assign out_valid     = valid_w[N];
	assign out_word.kept = rot_w[N].kept;
	assign out_word.done = rot_w[N].done;
	assign out_word.x    = rot_w[N].x;
	assign out_word.y    = rot_w[N].y;

endmodule

// ----- hdl/lsp_scale.sv -----
// Output scaler: CORDIC gain correction, rounding, offset and saturation.
// Two pipeline stages, the second is the output register; depends on lsp_pkg.
module lsp_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsp_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  lsp_pkg::vec_t                  in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           point_kept,
	output logic signed [lsp_pkg::OUT_W-1:0] point_x,
	output logic signed [lsp_pkg::OUT_W-1:0] point_y,
	output logic                           scan_done
);
	import lsp_pkg::*;

	function automatic logic signed [OUT_W-1:0] finish(
		input logic signed [PROD_W-1:0] p,
		input logic signed [OFF_W-1:0]  off
	);
		logic signed [PROD_W-1:0]           r;
		logic signed [PROD_W-FRAC_SHIFT-1:0] q;
		logic signed [SUM_W-1:0]            s;
		r = p + ROUND_HALF;
		q = r[PROD_W-1:FRAC_SHIFT];
		s = SUM_W'(q) + SUM_W'(off);
		if (s > SAT_HI) begin
			s = SAT_HI;
		end else if (s < SAT_LO) begin
			s = SAT_LO;
		end
		return s[OUT_W-1:0];
	endfunction

	logic                     valid_s1;
	logic                     kept_s1;
	logic                     done_s1;
	logic signed [PROD_W-1:0] px_s1;
	logic signed [PROD_W-1:0] py_s1;
	logic                     valid_s2;
	logic                     kept_s2;
	logic                     done_s2;
	logic signed [OUT_W-1:0]  x_s2;
	logic signed [OUT_W-1:0]  y_s2;

	logic                     rdy_s1;
	logic                     rdy_s2;

	assign rdy_s2   = !valid_s2 || out_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			kept_s1 <= in_word.kept;
			done_s1 <= in_word.done;
			px_s1   <= in_word.x * GAIN_Q30;
			py_s1   <= in_word.y * GAIN_Q30;
		end
		if (rdy_s2 && valid_s1) begin
			kept_s2 <= kept_s1;
			done_s2 <= done_s1;
			x_s2    <= kept_s1 ? finish(px_s1, cfg.offset_x) : '0;
			y_s2    <= kept_s1 ? finish(py_s1, cfg.offset_y) : '0;
		end
	end

	assign out_valid  = valid_s2;
	assign point_kept = kept_s2;
	assign scan_done  = done_s2;
	assign point_x    = x_s2;
	assign point_y    = y_s2;

endmodule

// ----- hdl/laser_scan_to_points_core.sv -----
// Lidar scan to points core: one range word in, one point word out, one word per clock
// while out_ready is held high. A word passes two front-end stages (window and angle),
// one CORDIC micro-rotation per stage, a gain multiply stage and a round/offset/saturate
// stage that is the output register. Every stage has its own valid bit and ready is formed
// stage by stage, so empty stages keep filling while the output is stalled. Configuration
// is taken at once and must only be written while no word is in flight. Top level; depends
// on lsp_pkg, lsp_front, lsp_cordic, lsp_scale and the assertion macro header.
`include "laser_scan_to_points_core_macros.svh"

module laser_scan_to_points_core #(
	parameter int unsigned MAX_SAMPLES   = 4096,
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lsp_pkg::RANGE_W-1:0]       range_mm,
	input  logic [lsp_pkg::IDX_W-1:0]         sample_index,
	input  logic                              scan_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              point_kept,
	output logic signed [lsp_pkg::OUT_W-1:0]  point_x,
	output logic signed [lsp_pkg::OUT_W-1:0]  point_y,
	output logic                              scan_done
);
	import lsp_pkg::*;

	cfg_t cfg_q;

	logic front_valid;
	logic front_ready;
	rot_t front_word;
	logic rot_valid;
	logic rot_ready;
	vec_t rot_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low   <= '0;
			cfg_q.range_high  <= 16'd4000;
			cfg_q.angle_start <= '0;
			cfg_q.angle_step  <= '0;
			cfg_q.offset_x    <= '0;
			cfg_q.offset_y    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RANGE_LOW:   cfg_q.range_low   <= cfg_data;
				REG_RANGE_HIGH:  cfg_q.range_high  <= cfg_data;
				REG_ANGLE_START: cfg_q.angle_start <= cfg_data;
				REG_ANGLE_STEP:  cfg_q.angle_step  <= $signed(cfg_data);
				REG_OFFSET_X:    cfg_q.offset_x    <= $signed(cfg_data);
				REG_OFFSET_Y:    cfg_q.offset_y    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	lsp_front #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.range_mm     (range_mm),
		.sample_index (sample_index),
		.scan_end     (scan_end),
		.out_valid    (front_valid),
		.out_ready    (front_ready),
		.out_word     (front_word)
	);

	lsp_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_word   (front_word),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_word  (rot_word)
	);

	lsp_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (rot_valid),
		.in_ready   (rot_ready),
		.in_word    (rot_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_kept (point_kept),
		.point_x    (point_x),
		.point_y    (point_y),
		.scan_done  (scan_done)
	);

	`LSTP_ASSERT_NOW(a_dropped_point_zero,
		out_valid && !point_kept,
		(point_x == '0) && (point_y == '0),
		"dropped point carries non-zero coordinates")
	`LSTP_ASSERT_NOW(a_inverted_window_drops,
		out_valid && (cfg_q.range_low > cfg_q.range_high),
		!point_kept,
		"point kept with inverted range window")
	`LSTP_ASSERT_NOW(a_ready_when_output_free,
		!out_valid || out_ready,
		in_ready,
		"input stalled while output stage can advance")

endmodule

// ----- test/tb_laser_scan_to_points_core.sv -----
// Testbench for laser_scan_to_points_core: streams lidar beams through the core and checks
// every point word against a fixed-point polar-to-Cartesian prediction held in a scoreboard.
// Depends on lsp_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_laser_scan_to_points_core;
	import lsp_pkg::*;

	localparam int     MAX_SAMPLES   = 4096;
	localparam int     CORDIC_STAGES = 16;
	localparam int     PIPE_LATENCY  = CORDIC_STAGES + 4;
	localparam int     RANDOM_BEAMS  = 1700;
	localparam longint GAIN          = 652032874;
	localparam longint ROUND_BIT     = longint'(1) << 43;
	localparam longint POINT_MAX     = 131071;
	localparam longint POINT_MIN     = -131072;
	localparam longint ATAN_TURN [CORDIC_STAGES] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861
	};

	class point_scoreboard;
		typedef struct {
			logic                    kept;
			logic signed [OUT_W-1:0] x;
			logic signed [OUT_W-1:0] y;
			logic                    done;
		} point_t;

		point_t                  pending_points[$];
		logic [RANGE_W-1:0]      range_low   = '0;
		logic [RANGE_W-1:0]      range_high  = 16'd4000;
		logic [ANG_W-1:0]        angle_start = '0;
		logic signed [ANG_W-1:0] angle_step  = '0;
		logic signed [OFF_W-1:0] offset_x    = '0;
		logic signed [OFF_W-1:0] offset_y    = '0;
		int                      errors;
		int                      checked;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (cfg_reg_t'(idx))
				REG_RANGE_LOW:   range_low = value;
				REG_RANGE_HIGH:  range_high = value;
				REG_ANGLE_START: angle_start = value;
				REG_ANGLE_STEP:  angle_step = value;
				REG_OFFSET_X:    offset_x = value;
				REG_OFFSET_Y:    offset_y = value;
				default: ;
			endcase
		endfunction

		function logic signed [OUT_W-1:0] scale_offset(longint acc, logic signed [OFF_W-1:0] off);
			longint v;
			v = ((acc * GAIN + ROUND_BIT) >>> 44) + longint'(off);
			if (v > POINT_MAX)
				v = POINT_MAX;
			if (v < POINT_MIN)
				v = POINT_MIN;
			return v[OUT_W-1:0];
		endfunction

		function point_t project_beam(logic [RANGE_W-1:0] r, logic [IDX_W-1:0] idx, logic fin);
			point_t         p;
			logic [ANG_W-1:0] ang;
			longint         sa, xa, ya, za, dx, dy;
			p.kept = (r >= range_low) && (r <= range_high) && (int'(idx) < MAX_SAMPLES);
			p.x = '0;
			p.y = '0;
			p.done = fin;
			if (p.kept) begin
				ang = angle_start + ANG_W'(ANG_W'(idx) * angle_step);
				sa = longint'($signed(ang));
				xa = longint'(r) * 16384;
				ya = 0;
				if (sa > 16384) begin
					sa -= 32768;
					xa = -xa;
				end else if (sa < -16384) begin
					sa += 32768;
					xa = -xa;
				end
				za = sa * 65536;
				for (int i = 0; i < CORDIC_STAGES; i++) begin
					dx = ya >>> i;
					dy = xa >>> i;
					if (za >= 0) begin
						xa -= dx;
						ya += dy;
						za -= ATAN_TURN[i];
					end else begin
						xa += dx;
						ya -= dy;
						za += ATAN_TURN[i];
					end
				end
				p.x = scale_offset(xa, offset_x);
				p.y = scale_offset(ya, offset_y);
			end
			return p;
		endfunction

		function void note_beam(logic [RANGE_W-1:0] r, logic [IDX_W-1:0] idx, logic fin);
			pending_points.insert(pending_points.size(), project_beam(r, idx, fin));
		endfunction

		function void report(string field, longint want, longint got);
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
		endfunction

		function void check_point(logic kept, logic signed [OUT_W-1:0] x,
				logic signed [OUT_W-1:0] y, logic done);
			point_t e;
			checked++;
			if (pending_points.size() == 0) begin
				errors++;
				$display("%0t: point word with none expected, actual kept=%0b x=%0d y=%0d done=%0b",
					$time, kept, x, y, done);
				return;
			end
			e = pending_points.pop_front();
			if (kept !== e.kept)
				report("point_kept", e.kept, kept);
			if (x !== e.x)
				report("point_x", e.x, x);
			if (y !== e.y)
				report("point_y", e.y, y);
			if (done !== e.done)
				report("scan_done", e.done, done);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [RANGE_W-1:0]      range_mm = '0;
	logic [IDX_W-1:0]        sample_index = '0;
	logic                    scan_end = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    point_kept;
	logic signed [OUT_W-1:0] point_x;
	logic signed [OUT_W-1:0] point_y;
	logic                    scan_done;

	int              send_idle_pct;
	int              recv_stall_pct;
	int              beams_sent;
	int              phases_run;
	point_scoreboard points = new();

	laser_scan_to_points_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.range_mm     (range_mm),
		.sample_index (sample_index),
		.scan_end     (scan_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_kept   (point_kept),
		.point_x      (point_x),
		.point_y      (point_y),
		.scan_done    (scan_done)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				points.note_beam(range_mm, sample_index, scan_end);
			if (out_valid && out_ready)
				points.check_point(point_kept, point_x, point_y, scan_done);
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		points.write_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic load_config(input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] start,
			input logic [15:0] step, input logic [15:0] ox, input logic [15:0] oy);
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, hi);
		write_reg(REG_ANGLE_START, start);
		write_reg(REG_ANGLE_STEP, step);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
	endtask

	task automatic send_beam(input logic [RANGE_W-1:0] r, input logic [IDX_W-1:0] idx,
			input logic fin);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		range_mm <= r;
		sample_index <= idx;
		scan_end <= fin;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		beams_sent++;
	endtask

	// hold off the sender until every point word is back
	task automatic drain();
		in_valid <= 1'b0;
		while (points.pending_points.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [RANGE_W-1:0] pick_range(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
		case ($urandom_range(5, 0))
			0: return RANGE_W'($urandom);
			1: begin
				case ($urandom_range(3, 0))
					0: return lo - 1'b1;
					1: return lo;
					2: return hi;
					default: return hi + 1'b1;
				endcase
			end
			default: begin
				if (lo <= hi)
					return RANGE_W'($urandom_range(int'(hi), int'(lo)));
				return RANGE_W'($urandom);
			end
		endcase
	endfunction

	task automatic random_phase(input int mode);
		logic [15:0] lo, hi, start, step, ox, oy;
		int          n, k, len, base;
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
			default: begin send_idle_pct = 9; recv_stall_pct = 9; end
		endcase
		start = 16'($urandom);
		step = 16'($urandom);
		ox = 16'($urandom);
		oy = 16'($urandom);
		case ($urandom_range(5, 0))
			0: begin
				lo = '0;
				hi = 16'hFFFF;
				case ($urandom_range(3, 0))
					0: step = 16'h8000;
					1: step = 16'h7FFF;
					2: step = '0;
					default: step = 16'hFFFF;
				endcase
				ox = $urandom_range(1, 0) ? 16'h8000 : 16'h7FFF;
				oy = $urandom_range(1, 0) ? 16'h8000 : 16'h7FFF;
			end
			1: begin
				lo = 16'($urandom);
				hi = lo;
			end
			2: begin
				lo = 16'($urandom_range(65535, 1));
				hi = 16'($urandom_range(int'(lo) - 1, 0));
			end
			default: begin
				lo = 16'($urandom_range(2000, 0));
				hi = 16'($urandom_range(65535, int'(lo)));
				if ($urandom_range(1, 0))
					step = 16'($urandom_range(64, 0) - 32);
			end
		endcase
		load_config(lo, hi, start, step, ox, oy);
		n = $urandom_range(140, 60);
		k = 0;
		while (k < n) begin
			case ($urandom_range(9, 0))
				0: begin
					send_beam(RANGE_W'($urandom), IDX_W'($urandom), 1'($urandom));
					k++;
				end
				1: begin
					base = $urandom_range(4095, 0);
					len = $urandom_range(40, 1);
					for (int j = 0; j < len; j++)
						send_beam(pick_range(lo, hi), IDX_W'(base + j), $urandom_range(7, 0) == 0);
					k += len;
				end
				default: begin
					len = ($urandom_range(7, 0) == 0) ? $urandom_range(600, 200) : $urandom_range(48, 4);
					for (int j = 0; j < len; j++)
						send_beam(pick_range(lo, hi), IDX_W'(j), j == len - 1);
					k += len;
				end
			endcase
		end
		drain();
		phases_run++;
	endtask

	initial begin
		int rand_start;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset window and angles
		send_beam(16'd0, 12'd0, 1'b0);
		send_beam(16'd4000, 12'd1, 1'b0);
		send_beam(16'd4001, 12'd2, 1'b1);
		drain();

		// full window, quarter and half turn boundaries, extreme offsets
		load_config(16'h0000, 16'hFFFF, 16'h0000, 16'd16, 16'h7FFF, 16'h8000);
		send_beam(16'hFFFF, 12'd0, 1'b0);
		send_beam(16'hFFFF, 12'd1024, 1'b0);
		send_beam(16'hFFFF, 12'd1025, 1'b0);
		send_beam(16'hFFFF, 12'd2048, 1'b0);
		send_beam(16'hFFFF, 12'd3071, 1'b0);
		send_beam(16'hFFFF, 12'd3072, 1'b0);
		send_beam(16'd1, 12'd4095, 1'b0);
		send_beam(16'd0, 12'd512, 1'b1);
		drain();

		// window edges, negative step, writes past the register list
		load_config(16'd100, 16'd60000, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF);
		for (int k = int'(REG_OFFSET_Y) + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(CFG_IDX_W'(k), 16'hFFFF);
		send_beam(16'd99, 12'd0, 1'b0);
		send_beam(16'd100, 12'd4095, 1'b0);
		send_beam(16'd60000, 12'd2047, 1'b0);
		send_beam(16'd60001, 12'd1, 1'b0);
		send_beam(16'hFFFF, 12'd3, 1'b1);
		drain();

		// inverted window drops everything
		load_config(16'd5000, 16'd4999, 16'd4000, 16'h7FFF, 16'd1234, 16'hFFFF);
		send_beam(16'd4999, 12'd0, 1'b0);
		send_beam(16'd5000, 12'd1, 1'b0);
		send_beam(16'd0, 12'd2, 1'b1);
		drain();

		rand_start = beams_sent;
		for (int p = 0; beams_sent - rand_start < RANDOM_BEAMS; p++)
			random_phase(p % 4);

		$display("Covered %0d beams over %0d random configurations plus directed edge cases;",
			beams_sent, phases_run);
		$display("%0d point words checked across all idle and stall modes, %0d mismatches.",
			points.checked, points.errors);
		if (points.errors == 0 && points.pending_points.size() == 0)
			$display("tb_laser_scan_to_points_core passed");
		else
			$display("tb_laser_scan_to_points_core failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d point words outstanding", points.pending_points.size());
		$display("tb_laser_scan_to_points_core failed");
		$finish;
	end

endmodule
